@@ design/srtq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package srtq_pkg;

   // table geometry
   localparam int TABLE_DEPTH  = 64;
   localparam int KEY_WIDTH    = 32;
   localparam int HANDLE_WIDTH = 32;
   localparam int IDX_W        = $clog2(TABLE_DEPTH);
   localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);

   // fixed field widths of the stream payloads
   localparam int OP_W     = 3;
   localparam int FKEY_W   = 32;
   localparam int FHDL_W   = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 6;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT    = 3'd0,
      OP_QUERY_EQ  = 3'd1,
      OP_QUERY_GT  = 3'd2,
      OP_QUERY_LT  = 3'd3,
      OP_CLEAR     = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NO_MATCH = 2'd2
   } status_type;

   // command broadcast to every cell
   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_COMPARE,
      CMD_INSERT,
      CMD_ROTATE
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_EXEC,
      ST_SCAN
   } state_type;

   typedef struct packed {
      cell_cmd_type              cmd;
      logic [KEY_WIDTH-1:0]      key;
      logic [HANDLE_WIDTH-1:0]   handle;
      logic [CNT_W-1:0]          count;
   } ctrl_type;

   typedef struct packed {
      logic [CNT_W-1:0]          lower;
      logic [CNT_W-1:0]          upper;
      logic [KEY_WIDTH-1:0]      tap_key;
      logic [HANDLE_WIDTH-1:0]   tap_handle;
   } chain_stat_type;

endpackage

`default_nettype wire

@@ design/sorted_key_table_range_query.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | payload
// ---------+-----+--------------------------------------------------------------------
// request  | in  | req_tdata: operation, key, handle
// response | out | rsp_tdata: status, entry_key, entry_handle, position; rsp_tlast: last
//
// a request is taken in idle; unless its op is unused, the sequencer passes through a compare
// and an execute state and takes no new request until it is back in idle; insert, clear and an
// empty query end there. a query with matches then rotates the valid entries past the head
// cell, one per cycle while no match is waiting, and holds the block until every valid entry
// has passed. execute and a match at the head both wait while the response register is full.
// reset empties the table (entry count zero); cell contents are not cleared.

module sorted_key_table_range_query (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // [2:0] operation, [34:3] key, [66:35] handle, [71:67] zero
   input  wire  [71:0]  req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // [1:0] status, [33:2] entry_key, [65:34] entry_handle, [71:66] position
   output logic [71:0]  rsp_tdata,
   output logic         rsp_tlast
);

   srtq_pkg::state_type                state_ff, state_in;
   logic [srtq_pkg::OP_W-1:0]          op_ff, op_in;
   logic [srtq_pkg::KEY_WIDTH-1:0]     key_ff, key_in;
   logic [srtq_pkg::HANDLE_WIDTH-1:0]  handle_ff, handle_in;
   logic [srtq_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [srtq_pkg::CNT_W-1:0]         start_ff, start_in;
   logic [srtq_pkg::CNT_W-1:0]         stop_ff, stop_in;
   logic [srtq_pkg::IDX_W-1:0]         rot_ff, rot_in;

   logic                               out_valid_ff, out_valid_in;
   srtq_pkg::status_type               out_status_ff, out_status_in;
   logic [srtq_pkg::FKEY_W-1:0]        out_key_ff, out_key_in;
   logic [srtq_pkg::FHDL_W-1:0]        out_handle_ff, out_handle_in;
   logic [srtq_pkg::POS_W-1:0]         out_pos_ff, out_pos_in;
   logic                               out_last_ff, out_last_in;

   srtq_pkg::ctrl_type                 ctrl;
   srtq_pkg::chain_stat_type           stat;
   logic                               req_xfer;
   logic                               can_load;
   logic [srtq_pkg::CNT_W-1:0]         rot_ext;
   logic                               tap_match;

   assign req_xfer = req_tvalid && req_tready;
   assign can_load = !out_valid_ff || rsp_tready;
   assign rot_ext  = srtq_pkg::CNT_W'(rot_ff);
   assign tap_match = (rot_ext >= start_ff) && (rot_ext < stop_ff);

   srtq_chain u_chain (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .stat  (stat)
   );

   // sequencer, chain command and response load
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      handle_in     = handle_ff;
      count_in      = count_ff;
      start_in      = start_ff;
      stop_in       = stop_ff;
      rot_in        = rot_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_key_in    = out_key_ff;
      out_handle_in = out_handle_ff;
      out_pos_in    = out_pos_ff;
      out_last_in   = out_last_ff;
      req_tready    = 1'b0;
      ctrl.cmd      = srtq_pkg::CMD_HOLD;
      ctrl.key      = key_ff;
      ctrl.handle   = handle_ff;
      ctrl.count    = count_ff;

      case (state_ff)
         srtq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_xfer) begin
               op_in     = req_tdata[2:0];
               key_in    = srtq_pkg::KEY_WIDTH'(req_tdata[34:3]);
               handle_in = srtq_pkg::HANDLE_WIDTH'(req_tdata[66:35]);
               if (req_tdata[2:0] <= srtq_pkg::OP_CLEAR) begin
                  state_in = srtq_pkg::ST_COMPARE;
               end
            end
         end

         srtq_pkg::ST_COMPARE: begin
            ctrl.cmd = srtq_pkg::CMD_COMPARE;
            state_in = srtq_pkg::ST_EXEC;
         end

         srtq_pkg::ST_EXEC: begin
            case (op_ff)
               srtq_pkg::OP_QUERY_EQ: begin
                  start_in = stat.lower;
                  stop_in  = stat.upper;
               end
               srtq_pkg::OP_QUERY_GT: begin
                  start_in = stat.upper;
                  stop_in  = count_ff;
               end
               srtq_pkg::OP_QUERY_LT: begin
                  start_in = '0;
                  stop_in  = stat.lower;
               end
               default: begin
                  start_in = '0;
                  stop_in  = '0;
               end
            endcase

            if (can_load) begin
               out_key_in    = '0;
               out_handle_in = '0;
               out_pos_in    = '0;
               out_last_in   = 1'b1;
               out_status_in = srtq_pkg::STATUS_OK;
               case (op_ff)
                  srtq_pkg::OP_INSERT: begin
                     out_valid_in = 1'b1;
                     state_in     = srtq_pkg::ST_IDLE;
                     if (count_ff == srtq_pkg::CNT_W'(srtq_pkg::TABLE_DEPTH)) begin
                        out_status_in = srtq_pkg::STATUS_FULL;
                     end else begin
                        ctrl.cmd   = srtq_pkg::CMD_INSERT;
                        count_in   = count_ff + 1'b1;
                        out_pos_in = srtq_pkg::POS_W'(stat.lower);
                     end
                  end
                  srtq_pkg::OP_CLEAR: begin
                     out_valid_in = 1'b1;
                     count_in     = '0;
                     state_in     = srtq_pkg::ST_IDLE;
                  end
                  default: begin
                     // query: empty run answers at once, else start the scan
                     rot_in = '0;
                     if (start_in >= stop_in) begin
                        out_valid_in  = 1'b1;
                        out_status_in = srtq_pkg::STATUS_NO_MATCH;
                        state_in      = srtq_pkg::ST_IDLE;
                     end else begin
                        state_in = srtq_pkg::ST_SCAN;
                     end
                  end
               endcase
            end
         end

         srtq_pkg::ST_SCAN: begin
            // head cell holds sorted entry rot_ff
            if (!tap_match || can_load) begin
               ctrl.cmd = srtq_pkg::CMD_ROTATE;
               rot_in   = rot_ff + 1'b1;
               if (tap_match) begin
                  out_valid_in  = 1'b1;
                  out_status_in = srtq_pkg::STATUS_OK;
                  out_key_in    = srtq_pkg::FKEY_W'(stat.tap_key);
                  out_handle_in = srtq_pkg::FHDL_W'(stat.tap_handle);
                  out_pos_in    = srtq_pkg::POS_W'(rot_ff);
                  out_last_in   = (rot_ext + 1'b1) == stop_ff;
               end
               if ((rot_ext + 1'b1) == count_ff) begin
                  state_in = srtq_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = srtq_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srtq_pkg::ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      handle_ff     <= handle_in;
      start_ff      <= start_in;
      stop_ff       <= stop_in;
      rot_ff        <= rot_in;
      out_status_ff <= out_status_in;
      out_key_ff    <= out_key_in;
      out_handle_ff <= out_handle_in;
      out_pos_ff    <= out_pos_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {out_pos_ff, out_handle_ff, out_key_ff, out_status_ff};

endmodule

`default_nettype wire

@@ design/srtq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srtq_cell (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire srtq_pkg::ctrl_type              ctrl,
   input  wire                                  valid,
   input  wire                                  is_end,
   input  wire                                  left_lt,
   input  wire [srtq_pkg::KEY_WIDTH-1:0]        left_key,
   input  wire [srtq_pkg::HANDLE_WIDTH-1:0]     left_handle,
   input  wire [srtq_pkg::KEY_WIDTH-1:0]        right_key,
   input  wire [srtq_pkg::HANDLE_WIDTH-1:0]     right_handle,
   input  wire [srtq_pkg::KEY_WIDTH-1:0]        wrap_key,
   input  wire [srtq_pkg::HANDLE_WIDTH-1:0]     wrap_handle,
   output logic [srtq_pkg::KEY_WIDTH-1:0]       key_ff,
   output logic [srtq_pkg::HANDLE_WIDTH-1:0]    handle_ff,
   output logic                                 lt_ff,
   output logic                                 le_ff
);

   logic [srtq_pkg::KEY_WIDTH-1:0]    key_in;
   logic [srtq_pkg::HANDLE_WIDTH-1:0] handle_in;
   logic                              lt_in;
   logic                              le_in;

   // next entry and compare flags
   always_comb begin
      key_in    = key_ff;
      handle_in = handle_ff;
      lt_in     = lt_ff;
      le_in     = le_ff;
      case (ctrl.cmd)
         srtq_pkg::CMD_COMPARE: begin
            lt_in = valid && (key_ff <  ctrl.key);
            le_in = valid && (key_ff <= ctrl.key);
         end
         srtq_pkg::CMD_INSERT: begin
            // entries below the insert point stay, the one at it takes the new pair
            if (!lt_ff) begin
               if (left_lt) begin
                  key_in    = ctrl.key;
                  handle_in = ctrl.handle;
               end else begin
                  key_in    = left_key;
                  handle_in = left_handle;
               end
            end
         end
         srtq_pkg::CMD_ROTATE: begin
            // ring over the valid entries, the last one takes the head
            if (is_end) begin
               key_in    = wrap_key;
               handle_in = wrap_handle;
            end else begin
               key_in    = right_key;
               handle_in = right_handle;
            end
         end
         default: begin
         end
      endcase
   end

   // entry payload
   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      handle_ff <= handle_in;
   end

   // compare flags
   always_ff @(posedge clock) begin
      if (reset) begin
         lt_ff <= 1'b0;
         le_ff <= 1'b0;
      end else begin
         lt_ff <= lt_in;
         le_ff <= le_in;
      end
   end

endmodule

`default_nettype wire

@@ design/srtq_chain.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srtq_chain (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire srtq_pkg::ctrl_type              ctrl,
   output srtq_pkg::chain_stat_type             stat
);

   localparam int DEPTH = srtq_pkg::TABLE_DEPTH;

   logic [srtq_pkg::KEY_WIDTH-1:0]    cell_key    [DEPTH];
   logic [srtq_pkg::HANDLE_WIDTH-1:0] cell_handle [DEPTH];
   logic [DEPTH-1:0]                  cell_lt;
   logic [DEPTH-1:0]                  cell_le;
   logic [DEPTH-1:0]                  lower_edge;
   logic [DEPTH-1:0]                  upper_edge;
   logic [srtq_pkg::CNT_W-1:0]        lower_enc;
   logic [srtq_pkg::CNT_W-1:0]        upper_enc;

   // row of cells, cell 0 is the head of the sorted order
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                              valid_w;
      logic                              end_w;
      logic                              left_lt_w;
      logic [srtq_pkg::KEY_WIDTH-1:0]    left_key_w;
      logic [srtq_pkg::HANDLE_WIDTH-1:0] left_handle_w;
      logic [srtq_pkg::KEY_WIDTH-1:0]    right_key_w;
      logic [srtq_pkg::HANDLE_WIDTH-1:0] right_handle_w;

      assign valid_w = srtq_pkg::CNT_W'(i) < ctrl.count;
      assign end_w   = srtq_pkg::CNT_W'(i + 1) == ctrl.count;

      if (i == 0) begin : g_head
         assign left_lt_w     = 1'b1;
         assign left_key_w    = ctrl.key;
         assign left_handle_w = ctrl.handle;
      end else begin : g_body
         assign left_lt_w     = cell_lt[i-1];
         assign left_key_w    = cell_key[i-1];
         assign left_handle_w = cell_handle[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_key_w    = cell_key[0];
         assign right_handle_w = cell_handle[0];
      end else begin : g_next
         assign right_key_w    = cell_key[i+1];
         assign right_handle_w = cell_handle[i+1];
      end

      srtq_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .valid        (valid_w),
         .is_end       (end_w),
         .left_lt      (left_lt_w),
         .left_key     (left_key_w),
         .left_handle  (left_handle_w),
         .right_key    (right_key_w),
         .right_handle (right_handle_w),
         .wrap_key     (cell_key[0]),
         .wrap_handle  (cell_handle[0]),
         .key_ff       (cell_key[i]),
         .handle_ff    (cell_handle[i]),
         .lt_ff        (cell_lt[i]),
         .le_ff        (cell_le[i])
      );

      // flag thermometers fall at the bound positions
      if (i == 0) begin : g_edge_head
         assign lower_edge[i] = !cell_lt[i];
         assign upper_edge[i] = !cell_le[i];
      end else begin : g_edge_body
         assign lower_edge[i] = cell_lt[i-1] && !cell_lt[i];
         assign upper_edge[i] = cell_le[i-1] && !cell_le[i];
      end
   end

   // one-hot edge to index, full table without edge gives the count
   always_comb begin
      lower_enc = '0;
      upper_enc = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (lower_edge[i]) lower_enc = lower_enc | srtq_pkg::CNT_W'(i);
         if (upper_edge[i]) upper_enc = upper_enc | srtq_pkg::CNT_W'(i);
      end
   end

   assign stat.lower      = (|lower_edge) ? lower_enc : ctrl.count;
   assign stat.upper      = (|upper_edge) ? upper_enc : ctrl.count;
   assign stat.tap_key    = cell_key[0];
   assign stat.tap_handle = cell_handle[0];

endmodule

`default_nettype wire

@@ bench/sorted_key_table_range_query_test.sv @@
`timescale 1ns / 1ps

module sorted_key_table_range_query_test;
   import srtq_pkg::*;

   localparam int REQ_W          = 72;
   localparam int REQ_PAD_W      = REQ_W - OP_W - FKEY_W - FHDL_W;
   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 5;
   localparam int STALL_LIMIT    = 3000;
   localparam int TAIL_CYCLES    = 2 * TABLE_DEPTH + 20;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int MAX_REPORTED   = 40;
   localparam int PHASE_ITEMS    = 110;

   // operation codes the block ignores
   localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_CLEAR + 1'b1;
   localparam logic [OP_W-1:0] OP_LAST_UNUSED  = '1;

   // one response as it appears on rsp_tdata, lowest field last
   typedef struct packed {
      logic [POS_W-1:0]    position;
      logic [FHDL_W-1:0]   entry_handle;
      logic [FKEY_W-1:0]   entry_key;
      logic [STATUS_W-1:0] status;
   } rsp_word_type;

   typedef struct {
      status_type          status;
      logic [FKEY_W-1:0]   entry_key;
      logic [FHDL_W-1:0]   entry_handle;
      logic [POS_W-1:0]    position;
      logic                last;
   } table_response_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   wire                req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;
   wire                rsp_tvalid;
   logic               rsp_tready = 1'b0;
   wire  [71:0]        rsp_tdata;
   wire                rsp_tlast;

   // shadow copy of the sorted table
   logic [KEY_WIDTH-1:0]    shadow_keys [TABLE_DEPTH];
   logic [HANDLE_WIDTH-1:0] shadow_handles [TABLE_DEPTH];
   int unsigned             shadow_count = 0;

   table_response_type pending_responses[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned rsp_hold_cycles = 0;
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;

   sorted_key_table_range_query uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #HALF_PERIOD clock = ~clock;

   task automatic report_mismatch(input string detail);
      mismatch_count++;
      // keep the log short on a badly broken block
      if (mismatch_count <= MAX_REPORTED)
         $display("mismatch at %0t ns: %s", $time, detail);
   endtask

   // first slot whose key is >= probe, or > probe when past_equal is set
   function automatic int unsigned bound_slot(input logic [KEY_WIDTH-1:0] probe,
                                              input bit past_equal);
      int unsigned slot;
      slot = 0;
      while (slot < shadow_count &&
             (past_equal ? shadow_keys[slot] <= probe : shadow_keys[slot] < probe))
         slot++;
      return slot;
   endfunction

   function automatic void expect_response(input status_type st,
                                           input logic [FKEY_W-1:0] ekey,
                                           input logic [FHDL_W-1:0] ehandle,
                                           input int unsigned pos, input logic last);
      table_response_type rec;
      rec.status       = st;
      rec.entry_key    = ekey;
      rec.entry_handle = ehandle;
      rec.position     = pos[POS_W-1:0];
      rec.last         = last;
      pending_responses.push_back(rec);
   endfunction

   // update the shadow table and queue the responses one request causes
   function automatic void apply_table_op(input logic [OP_W-1:0] op,
                                          input logic [FKEY_W-1:0] key,
                                          input logic [FHDL_W-1:0] handle);
      int unsigned run_start, run_stop, slot, i;
      bit is_query;
      run_start = 0;
      run_stop  = 0;
      is_query  = 1'b0;
      case (op)
         OP_INSERT: begin
            if (shadow_count >= TABLE_DEPTH) begin
               expect_response(STATUS_FULL, '0, '0, 0, 1'b1);
            end else begin
               slot = bound_slot(key[KEY_WIDTH-1:0], 1'b0);
               for (i = shadow_count; i > slot; i--) begin
                  shadow_keys[i]    = shadow_keys[i-1];
                  shadow_handles[i] = shadow_handles[i-1];
               end
               shadow_keys[slot]    = key[KEY_WIDTH-1:0];
               shadow_handles[slot] = handle[HANDLE_WIDTH-1:0];
               shadow_count++;
               expect_response(STATUS_OK, '0, '0, slot, 1'b1);
            end
         end
         OP_QUERY_EQ: begin
            is_query  = 1'b1;
            run_start = bound_slot(key[KEY_WIDTH-1:0], 1'b0);
            run_stop  = bound_slot(key[KEY_WIDTH-1:0], 1'b1);
         end
         OP_QUERY_GT: begin
            is_query  = 1'b1;
            run_start = bound_slot(key[KEY_WIDTH-1:0], 1'b1);
            run_stop  = shadow_count;
         end
         OP_QUERY_LT: begin
            is_query  = 1'b1;
            run_stop  = bound_slot(key[KEY_WIDTH-1:0], 1'b0);
         end
         OP_CLEAR: begin
            shadow_count = 0;
            expect_response(STATUS_OK, '0, '0, 0, 1'b1);
         end
         default: ;
      endcase
      // a query yields its run of entries, or a single no-match
      if (is_query) begin
         if (run_start >= run_stop)
            expect_response(STATUS_NO_MATCH, '0, '0, 0, 1'b1);
         else
            for (i = run_start; i < run_stop; i++)
               expect_response(STATUS_OK, shadow_keys[i], shadow_handles[i], i,
                               i + 1 == run_stop);
      end
   endfunction

   // offer one request, with random idle cycles ahead of it, until it is taken
   task automatic send_request(input logic [OP_W-1:0] op, input logic [FKEY_W-1:0] key,
                               input logic [FHDL_W-1:0] handle);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{REQ_PAD_W{1'b0}}, handle, key, op};
      do @(posedge clock); while (!req_tready);
      apply_table_op(op, key, handle);
   endtask

   // sender stays quiet until every queued response has come back
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_responses.size() != 0);
   endtask

   function automatic logic [FKEY_W-1:0] pick_key();
      int unsigned sel;
      sel = $urandom_range(99);
      // small keys give equal-key hits, zero and all ones the extremes, the rest spread over the full range
      if (sel < 45)
         return $urandom_range(15);
      else if (sel < 50)
         return '0;
      else if (sel < 55)
         return '1;
      else
         return $urandom();
   endfunction

   task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // empty table, field extremes, equal keys, unused op codes
   task automatic test_field_extremes();
      send_request(OP_CLEAR, '0, '0);
      send_request(OP_QUERY_EQ, '0, '0);
      send_request(OP_QUERY_GT, '0, '0);
      send_request(OP_QUERY_LT, '1, '1);
      send_request(OP_INSERT, '1, '0);
      send_request(OP_INSERT, '0, '1);
      send_request(OP_INSERT, 32'h8000_0000, 32'h5555_5555);
      send_request(OP_INSERT, 32'h8000_0000, 32'hAAAA_AAAA);
      send_request(OP_INSERT, '0, 32'h0000_0001);
      send_request(OP_QUERY_EQ, 32'h8000_0000, '0);
      send_request(OP_QUERY_EQ, '0, '1);
      send_request(OP_QUERY_EQ, 32'h0000_0005, '0);
      send_request(OP_QUERY_GT, '0, '0);
      send_request(OP_QUERY_GT, '1, '0);
      send_request(OP_QUERY_LT, '1, '0);
      send_request(OP_QUERY_LT, '0, '0);
      send_request(OP_QUERY_LT, 32'h8000_0000, '0);
      for (int code = OP_FIRST_UNUSED; code <= OP_LAST_UNUSED; code++)
         send_request(OP_W'(code), '1, '1);
      send_request(OP_QUERY_EQ, '1, '0);
      send_request(OP_CLEAR, '1, '1);
      send_request(OP_QUERY_GT, '0, '0);
   endtask

   // fill the table, overflow it, then read it back in full
   task automatic test_table_full();
      send_request(OP_CLEAR, '0, '0);
      for (int n = 0; n < TABLE_DEPTH + 2; n++)
         send_request(OP_INSERT, (n % 9 == 0) ? '1 : FKEY_W'($urandom_range(31)), $urandom());
      send_request(OP_QUERY_GT, '0, '0);
      send_request(OP_QUERY_LT, '1, '0);
      send_request(OP_QUERY_EQ, '1, '0);
      send_request(OP_QUERY_EQ, FKEY_W'($urandom_range(31)), '0);
      send_request(OP_CLEAR, '0, '0);
      send_request(OP_QUERY_LT, '1, '0);
   endtask

   // long response stall while queries keep coming, so the block backs up
   task automatic test_response_backpressure();
      send_request(OP_CLEAR, '0, '0);
      for (int n = 0; n < 24; n++)
         send_request(OP_INSERT, pick_key(), $urandom());
      wait_for_drain();
      rsp_hold_cycles = HOLD_OFF_CYCLES;
      for (int n = 0; n < 8; n++)
         send_request(n[0] ? OP_QUERY_LT : OP_QUERY_GT, n[0] ? '1 : '0, $urandom());
      wait_for_drain();
   endtask

   // well-formed random traffic; unused op codes do not count toward the goal
   task automatic test_random_traffic(input int unsigned item_goal);
      int unsigned done_items, pick;
      logic [OP_W-1:0] op;
      done_items = 0;
      while (done_items < item_goal) begin
         pick = $urandom_range(99);
         if (pick < 48)
            op = OP_INSERT;
         else if (pick < 63)
            op = OP_QUERY_EQ;
         else if (pick < 77)
            op = OP_QUERY_GT;
         else if (pick < 91)
            op = OP_QUERY_LT;
         else if (pick < 95)
            op = OP_CLEAR;
         else
            op = OP_W'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
         send_request(op, pick_key(), $urandom());
         if (op <= OP_CLEAR)
            done_items++;
         if ($urandom_range(49) == 0)
            wait_for_drain();
      end
   endtask

   // response ready: long hold-off when requested, else random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold_cycles != 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles = rsp_hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each response transfer with the oldest expectation
   always @(posedge clock) begin
      rsp_word_type       got;
      table_response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_responses.size() == 0) begin
            report_mismatch($sformatf("unexpected response %h last %b", rsp_tdata, rsp_tlast));
         end else begin
            want = pending_responses.pop_front();
            if (got.status !== want.status)
               report_mismatch($sformatf("status: expected %0d, got %0d",
                                         want.status, got.status));
            if (got.entry_key !== want.entry_key)
               report_mismatch($sformatf("entry_key: expected %h, got %h",
                                         want.entry_key, got.entry_key));
            if (got.entry_handle !== want.entry_handle)
               report_mismatch($sformatf("entry_handle: expected %h, got %h",
                                         want.entry_handle, got.entry_handle));
            if (got.position !== want.position)
               report_mismatch($sformatf("position: expected %0d, got %0d",
                                         want.position, got.position));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last: expected %b, got %b", want.last, rsp_tlast));
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles, %0d responses outstanding",
                  STALL_LIMIT, pending_responses.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      set_idling(21, 65);
      test_field_extremes();
      test_table_full();
      test_random_traffic(PHASE_ITEMS);

      set_idling(65, 21);
      test_response_backpressure();
      test_random_traffic(PHASE_ITEMS);

      set_idling(0, 0);
      test_random_traffic(PHASE_ITEMS);

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_responses.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ files.f @@
design/srtq_pkg.sv
design/srtq_cell.sv
design/srtq_chain.sv
design/sorted_key_table_range_query.sv
bench/sorted_key_table_range_query_test.sv
